>>> rtl/wmpc_pkg.sv
`timescale 1ns / 1ps
// Package with the shared field widths, item kinds and structs of the pattern counter.
package wmpc_pkg;

  // Field widths of the input and result items.
  localparam int FUNC_W      = 2;
  localparam int IDX_W       = 3;
  localparam int POS_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int LEN_FIELD_W = 7;
  localparam int OCNT_W      = 21;

  // A finish reports at most this many patterns.
  localparam int MAX_RESULTS = 8;

  // Bus widths: the packed fields rounded up to whole bytes.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_LENGTH = 2'd1,
    FUNC_SCAN   = 2'd2,
    FUNC_FINISH = 2'd3
  } func_t;

  // Control broadcast from the top level to every cell of the window.
  typedef struct packed {
    logic              shift;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_pat;
    logic [BYTE_W-1:0] wr_byte;
    logic              wr_wild;
    logic              rot;
    logic [IDX_W-1:0]  rot_pat;
  } cell_ctl_t;

  // One stored pattern position.
  typedef struct packed {
    logic              wild;
    logic [BYTE_W-1:0] byte_val;
  } pat_entry_t;

  // One result item, laid out as it appears on the output bus.
  typedef struct packed {
    logic              sat;
    logic              present;
    logic [OCNT_W-1:0] count;
    logic [IDX_W-1:0]  pattern;
  } result_t;

endpackage

>>> rtl/wmpc_cell.sv
`timescale 1ns / 1ps
// One window cell: a history byte, its slot of every pattern, and the per-pattern compare.
module wmpc_cell #(
  parameter int NUM_PATTERNS = 8,
  parameter int LEN_W        = 7,
  parameter int INDEX        = 0
) (
  input  logic                                   clk,
  input  wmpc_pkg::cell_ctl_t                    ctl,
  input  logic                                   wr_sel,
  input  logic [wmpc_pkg::BYTE_W-1:0]            hist_in,
  input  wmpc_pkg::pat_entry_t                   pat_in,
  input  logic [NUM_PATTERNS-1:0][LEN_W-1:0]     pat_len,
  output logic [wmpc_pkg::BYTE_W-1:0]            hist_out,
  output wmpc_pkg::pat_entry_t                   pat_out,
  output logic [NUM_PATTERNS-1:0]                pos_ok
);
  import wmpc_pkg::*;

  logic [BYTE_W-1:0] hist_r;
  pat_entry_t        slot_r [NUM_PATTERNS];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist_r <= hist_in;
    end
  end

  // Writes and ring rotation never happen in the same cycle.
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (ctl.wr_en && wr_sel && (int'(ctl.wr_pat) == p)) begin
        slot_r[p] <= '{wild: ctl.wr_wild, byte_val: ctl.wr_byte};
      end else if (ctl.rot && (int'(ctl.rot_pat) == p)) begin
        slot_r[p] <= pat_in;
      end
    end
  end

  always_comb begin
    pat_out = slot_r[0];
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (int'(ctl.rot_pat) == p) begin
        pat_out = slot_r[p];
      end
    end
  end

  // A cell beyond a pattern's length always agrees.
  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      pos_ok[p] = (INDEX >= int'(pat_len[p])) || slot_r[p].wild ||
                  (slot_r[p].byte_val == hist_r);
    end
  end

  assign hist_out = hist_r;

endmodule

>>> rtl/wmpc_out.sv
`timescale 1ns / 1ps
// Result queue: holds the counts of one finish and shifts them out one transfer at a time.
module wmpc_out #(
  parameter int NUM_RESULTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  wmpc_pkg::result_t    load_data [NUM_RESULTS],
  output logic                 can_load,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output wmpc_pkg::result_t    out_res,
  output logic                 out_tlast
);
  import wmpc_pkg::*;

  localparam int REM_W = $clog2(NUM_RESULTS + 1);

  result_t          slot_r [NUM_RESULTS];
  logic [REM_W-1:0] rem_r;
  logic             take;

  assign take       = out_tvalid && out_tready;
  assign out_tvalid = (rem_r != '0);
  assign out_tlast  = (rem_r == REM_W'(1));
  assign can_load   = !out_tvalid || (take && out_tlast);
  assign out_res    = slot_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= REM_W'(NUM_RESULTS);
    end else if (take) begin
      rem_r <= rem_r - REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= load_data;
    end else if (take) begin
      for (int k = 0; k < NUM_RESULTS - 1; k++) begin
        slot_r[k] <= slot_r[k + 1];
      end
    end
  end

endmodule

>>> rtl/wildcard_multi_pattern_counter.sv
`timescale 1ns / 1ps
// Top level of the wildcard multi-pattern byte counter.
//
// This block counts overlapping occurrences of up to NUM_PATTERNS byte patterns
// of up to MAX_LEN bytes each, with per-position wildcards, in a byte stream.
// The history window is a ring of MAX_LEN identical cells; each cell holds one
// history byte and the matching slot of every pattern, and compares them.
// Pattern bytes are stored right-aligned to the pattern's current length, so
// a scan byte is checked against all patterns in the cycle after its transfer
// and counts update without stalling: scan, pattern-write and finish items are
// taken one per clock. A length item that changes the alignment of a pattern
// rotates that pattern around the ring one cell per cycle, so input is held
// off until it has moved (new length - old length) mod MAX_LEN cells (a length of
// MAX_LEN aligns like zero). A finish copies the counts into a result queue
// and clears them at once; its min(NUM_PATTERNS, 8) results then leave one per
// cycle while out_tready is high, and scanning goes on. A further finish waits
// until the queue is empty or gives its final transfer in that cycle. No
// clearing pass follows reset. Counts saturate at 2^COUNT_WIDTH - 1.
module wildcard_multi_pattern_counter #(
  parameter int NUM_PATTERNS = 8,
  parameter int MAX_LEN      = 64,
  parameter int COUNT_WIDTH  = 21
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: pattern_index, position, byte_value, wildcard_req, length.
  input  logic [wmpc_pkg::IN_DATA_W-1:0]      in_tdata,
  // Field: func.
  input  logic [wmpc_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: result_pattern, occurrence_count, present, saturated.
  output logic [wmpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import wmpc_pkg::*;

  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int SLOT_W      = $clog2(MAX_LEN);
  localparam int SUM_W       = SLOT_W + 1;
  localparam int NUM_RESULTS = (NUM_PATTERNS < MAX_RESULTS) ? NUM_PATTERNS : MAX_RESULTS;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Bit positions of the input fields inside in_tdata.
  localparam int POS_LSB  = IDX_W;
  localparam int BYTE_LSB = POS_LSB + POS_W;
  localparam int WILD_BIT = BYTE_LSB + BYTE_W;
  localparam int LEN_LSB  = WILD_BIT + 1;

  // Unpacked input fields.
  func_t                  in_func;
  logic [IDX_W-1:0]       in_idx;
  logic [POS_W-1:0]       in_pos;
  logic [BYTE_W-1:0]      in_byte;
  logic                   in_wild;
  logic [LEN_FIELD_W-1:0] in_len;

  assign in_func = func_t'(in_tuser);
  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_pos  = in_tdata[POS_LSB +: POS_W];
  assign in_byte = in_tdata[BYTE_LSB +: BYTE_W];
  assign in_wild = in_tdata[WILD_BIT];
  assign in_len  = in_tdata[LEN_LSB +: LEN_FIELD_W];

  // State.
  logic [NUM_PATTERNS-1:0][LEN_W-1:0] len_r;
  logic [COUNT_WIDTH-1:0]             cnt_r   [NUM_PATTERNS];
  logic [COUNT_WIDTH-1:0]             cnt_nxt [NUM_PATTERNS];
  logic [COUNT_WIDTH-1:0]             cnt_upd [NUM_PATTERNS];
  logic [LEN_W-1:0]                   seen_r;
  logic                               scan_pend_r;
  logic [SLOT_W-1:0]                  rot_cnt_r;
  logic [IDX_W-1:0]                   rot_pat_r;

  // Handshake and item decode.
  logic accept;
  logic rot_busy;
  logic can_load;
  logic idx_ok;
  logic pos_in_range;
  logic do_write;
  logic do_length;
  logic do_scan;
  logic do_finish;

  assign rot_busy     = (rot_cnt_r != '0);
  assign in_tready    = !rot_busy && ((in_func != FUNC_FINISH) || can_load);
  assign accept       = in_tvalid && in_tready;
  assign idx_ok       = (int'(in_idx) < NUM_PATTERNS);
  assign pos_in_range = (int'(in_pos) < MAX_LEN);
  assign do_write     = accept && (in_func == FUNC_WRITE) && idx_ok && pos_in_range;
  assign do_length    = accept && (in_func == FUNC_LENGTH) && idx_ok;
  assign do_scan      = accept && (in_func == FUNC_SCAN);
  assign do_finish    = accept && (in_func == FUNC_FINISH);

  // Alignment: position j of a pattern of length L sits in cell (L - 1 - j) mod MAX_LEN.
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  new_len;
  logic [SLOT_W-1:0] cur_mod;
  logic [SLOT_W-1:0] new_mod;
  logic [SUM_W-1:0]  rot_sum;
  logic [SLOT_W-1:0] rot_amt;
  logic [SUM_W-1:0]  slot_sum;
  logic [SLOT_W-1:0] wr_slot;

  always_comb begin
    cur_len = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (int'(in_idx) == p) begin
        cur_len = len_r[p];
      end
    end
  end

  assign new_len = (int'(in_len) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(in_len);
  assign cur_mod = (cur_len == LEN_W'(MAX_LEN)) ? '0 : SLOT_W'(cur_len);
  assign new_mod = (new_len == LEN_W'(MAX_LEN)) ? '0 : SLOT_W'(new_len);

  assign rot_sum = SUM_W'(new_mod) + SUM_W'(MAX_LEN) - SUM_W'(cur_mod);
  assign rot_amt = (rot_sum >= SUM_W'(MAX_LEN)) ? SLOT_W'(rot_sum - SUM_W'(MAX_LEN))
                                                : SLOT_W'(rot_sum);

  assign slot_sum = SUM_W'(cur_mod) + SUM_W'(MAX_LEN - 1) - SUM_W'(in_pos);
  assign wr_slot  = (slot_sum >= SUM_W'(MAX_LEN)) ? SLOT_W'(slot_sum - SUM_W'(MAX_LEN))
                                                  : SLOT_W'(slot_sum);

  // Cell broadcast.
  cell_ctl_t ctl;

  always_comb begin
    ctl.shift   = do_scan;
    ctl.wr_en   = do_write;
    ctl.wr_pat  = in_idx;
    ctl.wr_byte = in_byte;
    ctl.wr_wild = in_wild;
    ctl.rot     = rot_busy;
    ctl.rot_pat = rot_pat_r;
  end

  // The ring of cells. History moves from cell k to k + 1 on a scan; during a
  // rotation the selected pattern moves the same way, the last cell feeding cell 0.
  logic [BYTE_W-1:0]       hist_w [MAX_LEN];
  pat_entry_t              pat_w  [MAX_LEN];
  logic [NUM_PATTERNS-1:0] ok_w   [MAX_LEN];

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    logic [BYTE_W-1:0] hist_src;
    pat_entry_t        pat_src;

    if (k == 0) begin : g_head
      assign hist_src = in_byte;
      assign pat_src  = pat_w[MAX_LEN - 1];
    end else begin : g_body
      assign hist_src = hist_w[k - 1];
      assign pat_src  = pat_w[k - 1];
    end

    wmpc_cell #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .LEN_W        (LEN_W),
      .INDEX        (k)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_sel   (wr_slot == SLOT_W'(k)),
      .hist_in  (hist_src),
      .pat_in   (pat_src),
      .pat_len  (len_r),
      .hist_out (hist_w[k]),
      .pat_out  (pat_w[k]),
      .pos_ok   (ok_w[k])
    );
  end

  // Match of the scan transferred in the previous cycle, and count update.
  logic [NUM_PATTERNS-1:0] all_ok;
  logic [NUM_PATTERNS-1:0] hit;

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      all_ok[p] = 1'b1;
      for (int k = 0; k < MAX_LEN; k++) begin
        all_ok[p] = all_ok[p] & ok_w[k][p];
      end
      hit[p] = scan_pend_r && (len_r[p] != '0) && (len_r[p] <= seen_r) && all_ok[p];
      cnt_upd[p] = (hit[p] && (cnt_r[p] != COUNT_MAX)) ? cnt_r[p] + COUNT_WIDTH'(1)
                                                        : cnt_r[p];
      cnt_nxt[p] = do_finish ? '0 : cnt_upd[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        cnt_r[p] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Lengths, bytes seen, pending scan and ring rotation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      seen_r      <= '0;
      scan_pend_r <= 1'b0;
      rot_cnt_r   <= '0;
      rot_pat_r   <= '0;
    end else begin
      scan_pend_r <= do_scan;
      if (do_finish) begin
        seen_r <= '0;
      end else if (do_scan && (seen_r < LEN_W'(MAX_LEN))) begin
        seen_r <= seen_r + LEN_W'(1);
      end
      if (do_length) begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
          if (int'(in_idx) == p) begin
            len_r[p] <= new_len;
          end
        end
        rot_cnt_r <= rot_amt;
        rot_pat_r <= in_idx;
      end else if (rot_busy) begin
        rot_cnt_r <= rot_cnt_r - SLOT_W'(1);
      end
    end
  end

  // Snapshot of the counts for a finish, including a match resolving this cycle.
  result_t res_load [NUM_RESULTS];
  result_t out_res;

  always_comb begin
    for (int k = 0; k < NUM_RESULTS; k++) begin
      res_load[k].pattern = IDX_W'(k);
      res_load[k].count   = OCNT_W'(cnt_upd[k]);
      res_load[k].present = (cnt_upd[k] != '0);
      res_load[k].sat     = (cnt_upd[k] == COUNT_MAX);
    end
  end

  wmpc_out #(
    .NUM_RESULTS (NUM_RESULTS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (do_finish),
    .load_data  (res_load),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'(out_res);

endmodule

>>> rtl/wmpc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the pattern counter, bound to the top level.
module wmpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [wmpc_pkg::FUNC_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wmpc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import wmpc_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset empties the result queue.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A finish starts a report with pattern zero in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_FINISH)
    |=> out_tvalid && (out_tdata[IDX_W-1:0] == '0))
    else $error("finish did not start a report at pattern zero");

  // Results of one report follow back to back in pattern order.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast
    |=> out_tvalid &&
        (out_tdata[IDX_W-1:0] == IDX_W'($past(out_tdata[IDX_W-1:0]) + IDX_W'(1))))
    else $error("report results out of order");

endmodule

bind wildcard_multi_pattern_counter wmpc_checker u_wmpc_checker (.*);
